@@ sv/qst_pkg.sv @@
// Package for the query string tokenizer: payload types, state codes, byte constants.
`default_nettype none
package qst_pkg;

  // Default entry buffer depth
  localparam int unsigned ENTRY_MAX_DEF = 64;

  // Characters with special meaning
  localparam logic [7:0] CHAR_EQ  = 8'h3D;  // '='
  localparam logic [7:0] CHAR_AMP = 8'h26;  // '&'
  localparam logic [7:0] CHAR_PCT = 8'h25;  // '%'

  // Input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } qst_in_t;

  // Result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       part;
    logic       part_empty;
    logic       part_last;
    logic       entry_last;
    logic       truncated;
  } qst_out_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_FILL,
    ST_START,
    ST_RD,
    ST_PROC
  } qst_state_e;

  // Percent-escape decode phase
  typedef enum logic [1:0] {
    DEC_NORM,
    DEC_PCT1,
    DEC_PCT2
  } qst_dec_e;

  // Hex digit decode: bit 4 is the valid flag, bits 3:0 the digit value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/query_string_tokenizer_top.sv @@
// Query string tokenizer: splits '&'-separated entries into percent-decoded key/value parts.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one query string byte per
// transaction, with in_last on the final byte. Output channel (out_valid_o/
// out_ready_i/out_data_o) gives one decoded byte or empty-part marker per transaction.
// Bytes of an entry are written to the entry buffer, one per cycle. At '&' or at the
// final byte the entry is drained: the controller reads the buffer one address at a
// time, issuing each read in ST_RD and decoding the byte in ST_PROC, and starts each
// part in ST_START; a percent escape consumes 3 stored bytes for one result. In_ready_o
// is low for the whole drain. An empty key gives its marker from ST_START without a
// buffer read.
// Fill and drain never overlap, so the buffer needs no forwarding.
// A full output register with out_ready_i low holds the drain in place; the last
// result of an entry may still wait there while the next entry fills.
// Reset clears the counters, flags and output valid; the buffer holds no reset value
// and only addresses written for the current entry are read.
`default_nettype none
module query_string_tokenizer_top #(
  parameter int unsigned ENTRY_MAX = qst_pkg::ENTRY_MAX_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire qst_pkg::qst_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output qst_pkg::qst_out_t     out_data_o
);
  import qst_pkg::*;

  localparam int unsigned AW = $clog2(ENTRY_MAX);

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  // Entry buffer
  qst_buf #(.ENTRY_MAX(ENTRY_MAX)) u_buf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Fill and drain control
  qst_ctrl #(.ENTRY_MAX(ENTRY_MAX)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

endmodule
`default_nettype wire

@@ sv/qst_buf.sv @@
// Entry buffer: single-port-write, registered-read synchronous memory.
`default_nettype none
module qst_buf #(
  parameter int unsigned ENTRY_MAX = qst_pkg::ENTRY_MAX_DEF,
  localparam int unsigned AW = $clog2(ENTRY_MAX)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);
  import qst_pkg::*;

  logic [7:0] mem [ENTRY_MAX];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/qst_ctrl.sv @@
// Tokenizer control: entry fill, split tracking, percent decode drain, output register.
`default_nettype none
module qst_ctrl #(
  parameter int unsigned ENTRY_MAX = qst_pkg::ENTRY_MAX_DEF,
  localparam int unsigned AW = $clog2(ENTRY_MAX),
  localparam int unsigned CW = $clog2(ENTRY_MAX + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire qst_pkg::qst_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output qst_pkg::qst_out_t     out_data_o,
  output logic                  we_o,
  output logic [AW-1:0]         waddr_o,
  output logic [7:0]            wdata_o,
  output logic                  re_o,
  output logic [AW-1:0]         raddr_o,
  input  wire logic [7:0]       rdata_i
);
  import qst_pkg::*;

  localparam logic [CW-1:0] MAX_CNT = CW'(ENTRY_MAX);

  qst_state_e state_q, state_d;
  qst_dec_e   ph_q, ph_d;
  logic [CW-1:0] cnt_q, cnt_d, split_q, split_d, a_q, a_d, hi_q, hi_d;
  logic          seen_q, seen_d, ovf_q, ovf_d, part_q, part_d, ok_q, ok_d;
  logic [7:0]    v_q, v_d;
  qst_out_t      out_q, out_d;
  logic          ov_q, ov_d;

  // Shared decode signals
  logic          in_fire, is_amp, room, flush;
  logic          out_free, last_pos, final_part, is_empty, part_more;
  logic [CW-1:0] a_inc, cnt_nx, split_nx;
  logic          seen_nx;
  logic [4:0]    hx;
  logic          emit;
  logic [7:0]    emit_byte;

  always_comb begin
    in_fire    = in_valid_i && in_ready_o;
    is_amp     = in_data_i.in_byte == CHAR_AMP;
    room       = cnt_q < MAX_CNT;
    cnt_nx     = cnt_q;
    split_nx   = split_q;
    seen_nx    = seen_q;
    if (!is_amp && room) begin
      cnt_nx = cnt_q + 1'b1;
      if (in_data_i.in_byte == CHAR_EQ && cnt_q != '0) begin
        split_nx = cnt_q;
        seen_nx  = 1'b1;
      end
    end
    flush      = in_fire && (is_amp || in_data_i.in_last);
    out_free   = !ov_q || out_ready_i;
    a_inc      = a_q + 1'b1;
    last_pos   = a_inc >= hi_q;
    final_part = part_q || !seen_q;
    part_more  = !part_q && seen_q;
    is_empty   = a_q == hi_q;
    hx         = hex_digit(rdata_i);
    // Does the byte in hand produce a result this cycle
    emit      = 1'b0;
    emit_byte = rdata_i;
    unique case (ph_q)
      DEC_NORM: begin
        if (rdata_i == CHAR_PCT) begin
          emit      = last_pos;
          emit_byte = 8'h00;
        end else begin
          emit = 1'b1;
        end
      end
      DEC_PCT1: begin
        emit      = last_pos;
        emit_byte = hx[4] ? {4'h0, hx[3:0]} : 8'h00;
      end
      DEC_PCT2: begin
        emit      = 1'b1;
        emit_byte = (ok_q && hx[4]) ? {v_q[3:0], hx[3:0]} : v_q;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FILL: begin
        if (flush) state_d = ST_START;
      end
      ST_START: begin
        if (!is_empty) begin
          state_d = ST_RD;
        end else if (out_free) begin
          state_d = part_more ? ST_START : ST_FILL;
        end
      end
      ST_RD: begin
        state_d = ST_PROC;
      end
      ST_PROC: begin
        if (!emit || !last_pos) begin
          if (!emit || out_free) state_d = ST_RD;
        end else if (out_free) begin
          state_d = part_more ? ST_START : ST_FILL;
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cnt_d   = cnt_q;
    split_d = split_q;
    seen_d  = seen_q;
    ovf_d   = ovf_q;
    part_d  = part_q;
    a_d     = a_q;
    hi_d    = hi_q;
    ph_d    = ph_q;
    v_d     = v_q;
    ok_d    = ok_q;
    out_d   = out_q;
    ov_d    = ov_q && !out_ready_i;
    we_o    = 1'b0;
    waddr_o = cnt_q[AW-1:0];
    wdata_o = in_data_i.in_byte;
    re_o    = 1'b0;
    raddr_o = a_q[AW-1:0];
    in_ready_o = state_q == ST_FILL;
    unique case (state_q)
      ST_FILL: begin
        if (in_fire) begin
          if (!is_amp) begin
            if (room) we_o = 1'b1;
            else      ovf_d = 1'b1;
          end
          cnt_d   = cnt_nx;
          split_d = split_nx;
          seen_d  = seen_nx;
          // Start drain with the key part
          part_d = 1'b0;
          a_d    = '0;
          hi_d   = seen_nx ? split_nx : cnt_nx;
          ph_d   = DEC_NORM;
        end
      end
      ST_START: begin
        if (is_empty && out_free) begin
          out_d.out_byte   = 8'h00;
          out_d.part       = part_q;
          out_d.part_empty = 1'b1;
          out_d.part_last  = 1'b1;
          out_d.entry_last = final_part;
          out_d.truncated  = ovf_q;
          ov_d             = 1'b1;
        end
      end
      ST_RD: begin
        re_o = 1'b1;
      end
      ST_PROC: begin
        if (!emit) begin
          a_d = a_inc;
          if (ph_q == DEC_NORM) begin
            ph_d = DEC_PCT1;
          end else begin
            ph_d = DEC_PCT2;
            v_d  = hx[4] ? {4'h0, hx[3:0]} : 8'h00;
            ok_d = hx[4];
          end
        end else if (out_free) begin
          out_d.out_byte   = emit_byte;
          out_d.part       = part_q;
          out_d.part_empty = 1'b0;
          out_d.part_last  = last_pos;
          out_d.entry_last = last_pos && final_part;
          out_d.truncated  = ovf_q;
          ov_d             = 1'b1;
          ph_d             = DEC_NORM;
          a_d              = a_inc;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
    // End of a part: move to the value or clear the entry
    if ((state_q == ST_START && is_empty && out_free) ||
        (state_q == ST_PROC && emit && last_pos && out_free)) begin
      if (part_more) begin
        part_d = 1'b1;
        a_d    = split_q + 1'b1;
        hi_d   = cnt_q;
        ph_d   = DEC_NORM;
      end else begin
        cnt_d   = '0;
        split_d = '0;
        seen_d  = 1'b0;
        ovf_d   = 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      ph_q    <= DEC_NORM;
      cnt_q   <= '0;
      split_q <= '0;
      seen_q  <= 1'b0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      cnt_q   <= cnt_d;
      split_q <= split_d;
      seen_q  <= seen_d;
      ovf_q   <= ovf_d;
      ov_q    <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    a_q    <= a_d;
    hi_q   <= hi_d;
    v_q    <= v_d;
    ok_q   <= ok_d;
    out_q  <= out_d;
  end

endmodule
`default_nettype wire

@@ sv/qst_checker.sv @@
// Port-level checker for the query string tokenizer, bound to the top level.
`default_nettype none
module qst_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire qst_pkg::qst_in_t in_data_i,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire qst_pkg::qst_out_t out_data_o
);
  import qst_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // An empty marker carries a zero byte and closes its part
  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.part_empty |->
      out_data_o.out_byte == 8'h00 && out_data_o.part_last)
    else $error("bad empty marker");

  // The end of an entry is also the end of a part
  a_entry_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.entry_last |-> out_data_o.part_last)
    else $error("entry_last without part_last");

  // A separator starts a drain, so input stops next cycle
  a_amp_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.in_byte == CHAR_AMP |=> !in_ready_o)
    else $error("input taken right after separator");

endmodule

bind query_string_tokenizer_top qst_checker u_qst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

@@ tb/query_string_tokenizer_top_test.sv @@
// Testbench for the query string tokenizer: random and directed query strings, scoreboarded.
module query_string_tokenizer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import qst_pkg::*;

  localparam int unsigned ENTRY_DEPTH = ENTRY_MAX_DEF;
  localparam int unsigned ITEM_TARGET = 430;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef logic [7:0] byte_q_t[$];

  // Expected token stream for the byte stream accepted so far
  class token_scoreboard;
    logic [7:0]  entry_q[ENTRY_DEPTH];
    int unsigned fill;
    int unsigned split_at;
    bit          has_split;
    bit          lost_bytes;
    qst_out_t    tokens_due[$];
    int unsigned mismatches;

    function new();
      fill       = 0;
      split_at   = 0;
      has_split  = 1'b0;
      lost_bytes = 1'b0;
      mismatches = 0;
    endfunction

    // Hex digit value, or -1 for anything else
    function int digit_value(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
    endfunction

    function void push_token(logic [7:0] value, logic part, logic empty);
      qst_out_t t;
      t = '{out_byte: value, part: part, part_empty: empty, part_last: 1'b0,
            entry_last: 1'b0, truncated: lost_bytes};
      tokens_due.push_back(t);
    endfunction

    // Decode buffer range [lo, hi) as one part
    function void decode_part(int unsigned lo, int unsigned hi, logic part, bit ends_entry);
      int unsigned i;
      int unsigned start;
      int          d1;
      int          d2;
      logic [7:0]  v;
      start = tokens_due.size();
      i = lo;
      while (i < hi) begin
        if (entry_q[i] == CHAR_PCT) begin
          v = 8'h00;
          if (i + 1 < hi) begin
            d1 = digit_value(entry_q[i + 1]);
            if (d1 >= 0) begin
              v = 8'(d1);
              if (i + 2 < hi) begin
                d2 = digit_value(entry_q[i + 2]);
                if (d2 >= 0) v = 8'(d1 * 16 + d2);
              end
            end
          end
          push_token(v, part, 1'b0);
          i += 3;
        end else begin
          push_token(entry_q[i], part, 1'b0);
          i += 1;
        end
      end
      if (tokens_due.size() == start) push_token(8'h00, part, 1'b1);
      tokens_due[tokens_due.size() - 1].part_last = 1'b1;
      if (ends_entry) tokens_due[tokens_due.size() - 1].entry_last = 1'b1;
    endfunction

    function void flush_entry();
      if (has_split) begin
        decode_part(0, split_at, 1'b0, 1'b0);
        decode_part(split_at + 1, fill, 1'b1, 1'b1);
      end else begin
        decode_part(0, fill, 1'b0, 1'b1);
      end
      fill       = 0;
      split_at   = 0;
      has_split  = 1'b0;
      lost_bytes = 1'b0;
    endfunction

    // Accepted input byte
    function void note_byte(qst_in_t item);
      if (item.in_byte == CHAR_AMP) begin
        flush_entry();
        return;
      end
      if (fill < ENTRY_DEPTH) begin
        if (item.in_byte == CHAR_EQ && fill > 0) begin
          split_at  = fill;
          has_split = 1'b1;
        end
        entry_q[fill] = item.in_byte;
        fill++;
      end else begin
        lost_bytes = 1'b1;
      end
      if (item.in_last && fill > 0) flush_entry();
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Accepted output token against the oldest expectation
    task check_token(qst_out_t got);
      qst_out_t want;
      if (tokens_due.size() == 0) begin
        report_mismatch($sformatf("unexpected token %p", got));
        return;
      end
      want = tokens_due.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
      if (got.part !== want.part)
        report_mismatch($sformatf("part %b, want %b", got.part, want.part));
      if (got.part_empty !== want.part_empty)
        report_mismatch($sformatf("part_empty %b, want %b", got.part_empty, want.part_empty));
      if (got.part_last !== want.part_last)
        report_mismatch($sformatf("part_last %b, want %b", got.part_last, want.part_last));
      if (got.entry_last !== want.entry_last)
        report_mismatch($sformatf("entry_last %b, want %b", got.entry_last, want.entry_last));
      if (got.truncated !== want.truncated)
        report_mismatch($sformatf("truncated %b, want %b", got.truncated, want.truncated));
    endtask
  endclass

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  qst_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  qst_out_t out_data_o;

  token_scoreboard scoreboard = new();
  bit              idle_on    = 1'b1;
  int unsigned     hold_req   = 0;
  int unsigned     items_sent = 0;
  int unsigned     cycles     = 0;

  query_string_tokenizer_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: check tokens, random stall bursts, one long hold-off on request
  always @(posedge clk_i) begin
    int unsigned hold_left;
    int unsigned stall_left;
    if (rst_ni && out_valid_o && out_ready_i) scoreboard.check_token(out_data_o);
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // One input transaction, with an optional idle burst in front
  task automatic send_byte(logic [7:0] value, logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= qst_in_t'{in_byte: value, in_last: last};
    do @(posedge clk_i); while (!in_ready_o);
    scoreboard.note_byte(qst_in_t'{in_byte: value, in_last: last});
    items_sent++;
  endtask

  task automatic send_query(byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic send_text(string s, bit mark_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], mark_last && i == s.len() - 1);
  endtask

  // Drop valid and wait until all expected tokens are out
  task automatic wait_for_tokens();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (scoreboard.tokens_due.size() != 0);
  endtask

  function automatic logic [7:0] hex_char();
    int unsigned d;
    d = $urandom_range(0, 15);
    if (d < 10) return 8'h30 + 8'(d);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(d - 10);
  endfunction

  function automatic logic [7:0] plain_char();
    case ($urandom_range(0, 3))
      0:       return 8'h61 + 8'($urandom_range(0, 25));
      1:       return 8'h41 + 8'($urandom_range(0, 25));
      2:       return 8'h30 + 8'($urandom_range(0, 9));
      default: return ($urandom_range(0, 1) ? 8'h2D : 8'h5F);
    endcase
  endfunction

  // Plain text with well-formed escapes mixed in
  function automatic void add_text(ref byte_q_t q, input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) begin
        q.push_back(CHAR_PCT);
        q.push_back(hex_char());
        q.push_back(hex_char());
      end else begin
        q.push_back(plain_char());
      end
    end
  endfunction

  function automatic void add_entry(ref byte_q_t q, input bit want_long);
    int unsigned kind;
    kind = want_long ? 19 : $urandom_range(0, 24);
    if (kind < 14) begin
      // key[=value], sometimes '=' leading or repeated
      if ($urandom_range(0, 7) == 0) q.push_back(CHAR_EQ);
      add_text(q, $urandom_range(0, 8));
      if ($urandom_range(0, 4) != 0) begin
        q.push_back(CHAR_EQ);
        add_text(q, $urandom_range(0, 8));
        if ($urandom_range(0, 9) == 0) begin
          q.push_back(CHAR_EQ);
          add_text(q, $urandom_range(0, 3));
        end
      end
    end else if (kind < 17) begin
      // broken or truncated escape
      add_text(q, $urandom_range(0, 3));
      q.push_back(CHAR_PCT);
      repeat ($urandom_range(0, 2)) q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) q.push_back(CHAR_EQ);
      add_text(q, $urandom_range(0, 2));
    end else if (kind < 19) begin
      // raw noise
      repeat ($urandom_range(1, 10)) q.push_back(8'($urandom_range(0, 255)));
    end else begin
      // overlong entry, split point may land past the buffer end
      add_text(q, $urandom_range(30, 70));
      q.push_back(CHAR_EQ);
      add_text(q, $urandom_range(5, 30));
    end
  endfunction

  function automatic byte_q_t build_query(bit want_long);
    byte_q_t q;
    int unsigned n;
    n = $urandom_range(1, 4);
    if ($urandom_range(0, 9) == 0) q.push_back(CHAR_AMP);
    for (int unsigned e = 0; e < n; e++) begin
      if (e > 0) q.push_back(CHAR_AMP);
      add_entry(q, want_long && e == 0);
    end
    if ($urandom_range(0, 4) == 0 || q.size() == 0) q.push_back(CHAR_AMP);
    return q;
  endfunction

  // Stimulus
  initial begin
    byte_q_t q;
    bit      hold_done;
    bit      pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty entry, leading '=', empty value ending the string on '&',
    // byte extremes, bad and short escapes, escape near part end
    send_text("&", 1'b0);
    send_text("=x&", 1'b0);
    send_text("k=&", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CHAR_AMP, 1'b0);
    send_text("%zz=%4&", 1'b0);
    send_text("a%4=%41", 1'b1);
    wait_for_tokens();

    // Random query strings
    while (items_sent < ITEM_TARGET) begin
      if (items_sent > ITEM_TARGET - 70) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      if (!hold_done && items_sent > 150) begin
        // receiver holds off while the sender keeps offering
        hold_done = 1'b1;
        hold_req  = 300;
        q = build_query(1'b1);
        send_query(q);
        q = build_query(1'b1);
      end else begin
        q = build_query($urandom_range(0, 24) == 0);
      end
      send_query(q);
      if (!pause_done && items_sent > 260) begin
        pause_done = 1'b1;
        wait_for_tokens();
      end
    end

    wait_for_tokens();
    repeat (40) @(posedge clk_i);
    if (scoreboard.mismatches == 0 && scoreboard.tokens_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
